// ===== src/etal_pkg.sv =====
// Shared types and constants for the event threshold alert limiter.
`timescale 1ns / 1ps
`default_nettype none

package etal_pkg;

	localparam int unsigned KIND_COUNT = 5;
	localparam int unsigned KIND_W     = 3;
	localparam int unsigned DATA_W     = 32;

	// Action codes carried on the item channel.
	localparam logic [KIND_W-1:0] ACT_DROP    = 3'd0;
	localparam logic [KIND_W-1:0] ACT_RESET   = 3'd1;
	localparam logic [KIND_W-1:0] ACT_NOMEM   = 3'd2;
	localparam logic [KIND_W-1:0] ACT_LATENCY = 3'd3;
	localparam logic [KIND_W-1:0] ACT_LIMITER = 3'd4;
	localparam logic [KIND_W-1:0] ACT_TICK    = 3'd5;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ENABLE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DROP_THR  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_THR = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_NOMEM_THR = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_LIMIT_THR = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LATENCY   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN  = 3'd6;

	typedef struct packed {
		logic              alerts_enabled;
		logic [DATA_W-1:0] drop_threshold;
		logic [DATA_W-1:0] reset_threshold;
		logic [DATA_W-1:0] nomem_threshold;
		logic [DATA_W-1:0] limiter_threshold;
		logic [DATA_W-1:0] latency_limit_us;
		logic [DATA_W-1:0] cooldown_ticks;
	} cfg_t;

endpackage

`default_nettype wire

// ===== src/event_threshold_alert_limiter.sv =====
// Event threshold alert limiter: top level.
//
// Items arrive on the item channel (item_valid / item_stall) as one beat each:
// an action code with a latency sample and a tick count. Drop, TCP reset,
// allocation failure, latency and rate-limit actions bump a saturating
// per-kind counter and may raise an alert; a tick latches the time and clears
// all counters. Actions 6 and 7 are dropped without effect.
// Alerts leave on the alert channel (alert_valid / alert_stall), at most one
// per item. The configuration channel (cfg_valid / cfg_ready) takes one
// register write per cycle and is always ready; write it only while idle.
// An accepted item waits in the input register, where a single pass of
// increment, threshold compare and cooldown subtract updates the state and
// loads the result register. An alert is therefore shown from the edge at
// which the item leaves the input register.
// One item is taken every cycle while the alert side is free.
// When the receiver stalls a pending alert, the input register holds its
// item and item_stall rises; nothing is lost.
// Reset clears the counters, last-alert times and current time to zero and
// loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module event_threshold_alert_limiter (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            item_valid,
	output logic                                 item_stall,
	input  wire logic [etal_pkg::KIND_W-1:0]     action,
	input  wire logic [etal_pkg::DATA_W-1:0]     sample_us,
	input  wire logic [etal_pkg::DATA_W-1:0]     now_ticks,
	output logic                                 alert_valid,
	input  wire logic                            alert_stall,
	output logic [etal_pkg::KIND_W-1:0]          alert_kind,
	output logic [etal_pkg::DATA_W-1:0]          event_count,
	output logic [etal_pkg::DATA_W-1:0]          latency_value,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [etal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [etal_pkg::DATA_W-1:0]     cfg_data
);
	import etal_pkg::*;

	cfg_t cfg;

	etal_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// Input register.
	logic              valid_s1;
	logic [KIND_W-1:0] action_s1;
	logic [DATA_W-1:0] duration_s1;
	logic [DATA_W-1:0] now_s1;

	// Block state.
	logic [DATA_W-1:0] counter_q [KIND_COUNT];
	logic [DATA_W-1:0] last_alert_q [KIND_COUNT];
	logic [DATA_W-1:0] time_q;

	// Result register.
	logic              alert_valid_q;
	logic [KIND_W-1:0] alert_kind_q;
	logic [DATA_W-1:0] event_count_q;
	logic [DATA_W-1:0] latency_value_q;

	logic              out_free;
	logic              advance;
	logic              item_take;
	logic              is_kind;
	logic              is_tick;
	logic              is_latency;
	logic [DATA_W-1:0] count_sel;
	logic [DATA_W-1:0] last_sel;
	logic [DATA_W-1:0] thr_sel;
	logic [DATA_W-1:0] count_next;
	logic [DATA_W-1:0] elapsed;
	logic              hit;
	logic              fire;

	assign out_free   = !alert_valid_q || !alert_stall;
	assign advance    = valid_s1 && out_free;
	assign item_stall = valid_s1 && !out_free;
	assign item_take  = item_valid && !item_stall;

	assign is_kind    = (action_s1 < ACT_TICK);
	assign is_tick    = (action_s1 == ACT_TICK);
	assign is_latency = (action_s1 == ACT_LATENCY);

	always_comb begin
		count_sel = '0;
		last_sel  = '0;
		for (int k = 0; k < KIND_COUNT; k++) begin
			if (action_s1 == KIND_W'(k)) begin
				count_sel = counter_q[k];
				last_sel  = last_alert_q[k];
			end
		end
	end

	always_comb begin
		unique case (action_s1)
			ACT_DROP:  thr_sel = cfg.drop_threshold;
			ACT_RESET: thr_sel = cfg.reset_threshold;
			ACT_NOMEM: thr_sel = cfg.nomem_threshold;
			default:   thr_sel = cfg.limiter_threshold;
		endcase
	end

	// The counter saturates at all ones.
	assign count_next = (&count_sel) ? count_sel : count_sel + DATA_W'(1);
	// Modular difference: wraparound of the tick count is harmless.
	assign elapsed    = time_q - last_sel;
	assign hit        = is_latency ? (duration_s1 >= cfg.latency_limit_us)
	                               : (count_next >= thr_sel);
	assign fire       = is_kind && cfg.alerts_enabled && hit
	                    && (elapsed >= cfg.cooldown_ticks);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			action_s1   <= action;
			duration_s1 <= sample_us;
			now_s1      <= now_ticks;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
			for (int k = 0; k < KIND_COUNT; k++) begin
				counter_q[k]    <= '0;
				last_alert_q[k] <= '0;
			end
		end else if (advance) begin
			if (is_tick) begin
				time_q <= now_s1;
				for (int k = 0; k < KIND_COUNT; k++) begin
					counter_q[k] <= '0;
				end
			end else begin
				for (int k = 0; k < KIND_COUNT; k++) begin
					if (action_s1 == KIND_W'(k)) begin
						counter_q[k] <= count_next;
						if (fire) begin
							last_alert_q[k] <= time_q;
						end
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alert_valid_q <= 1'b0;
		end else if (advance) begin
			alert_valid_q <= fire;
		end else if (!alert_stall) begin
			alert_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			alert_kind_q    <= action_s1;
			event_count_q   <= count_next;
			latency_value_q <= is_latency ? duration_s1 : '0;
		end
	end

	assign alert_valid   = alert_valid_q;
	assign alert_kind    = alert_kind_q;
	assign event_count   = event_count_q;
	assign latency_value = latency_value_q;

endmodule

`default_nettype wire

// ===== src/etal_cfg_regs.sv =====
// Configuration register file of the alert limiter.
`timescale 1ns / 1ps
`default_nettype none

module etal_cfg_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [etal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [etal_pkg::DATA_W-1:0]     cfg_data,
	output etal_pkg::cfg_t                       cfg
);
	import etal_pkg::*;

	cfg_t cfg_q;

	// Every beat is taken at once.
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.alerts_enabled    <= 1'b1;
			cfg_q.drop_threshold    <= 32'd100;
			cfg_q.reset_threshold   <= 32'd100;
			cfg_q.nomem_threshold   <= 32'd10;
			cfg_q.limiter_threshold <= 32'd100;
			cfg_q.latency_limit_us  <= 32'd100000;
			cfg_q.cooldown_ticks    <= 32'd6000;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ENABLE:    cfg_q.alerts_enabled    <= cfg_data[0];
				REG_DROP_THR:  cfg_q.drop_threshold    <= cfg_data;
				REG_RESET_THR: cfg_q.reset_threshold   <= cfg_data;
				REG_NOMEM_THR: cfg_q.nomem_threshold   <= cfg_data;
				REG_LIMIT_THR: cfg_q.limiter_threshold <= cfg_data;
				REG_LATENCY:   cfg_q.latency_limit_us  <= cfg_data;
				REG_COOLDOWN:  cfg_q.cooldown_ticks    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== src/etal_checker.sv =====
// Port-level assertions for the alert limiter and their bind.
`timescale 1ns / 1ps
`default_nettype none

module etal_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            alert_valid,
	input wire logic                            alert_stall,
	input wire logic [etal_pkg::KIND_W-1:0]     alert_kind,
	input wire logic [etal_pkg::DATA_W-1:0]     event_count,
	input wire logic [etal_pkg::DATA_W-1:0]     latency_value
);
	import etal_pkg::*;

	// A stalled alert beat stays up.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid && alert_stall |=> alert_valid)
		else $error("alert beat dropped while stalled");

	// A stalled alert beat keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid && alert_stall |=>
			$stable(alert_kind) && $stable(event_count) && $stable(latency_value))
		else $error("alert payload changed while stalled");

	// Only the five event kinds can alert; a tick never does.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid |-> alert_kind < ACT_TICK)
		else $error("alert with a kind that cannot fire");

	// The counter is bumped before the threshold check, so it is never zero.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid |-> event_count != '0)
		else $error("alert with zero event count");

	// Only a latency alert carries a duration.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		alert_valid && alert_kind != ACT_LATENCY |-> latency_value == '0)
		else $error("non-latency alert carries a duration");

endmodule

bind event_threshold_alert_limiter etal_checker u_etal_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.alert_valid   (alert_valid),
	.alert_stall   (alert_stall),
	.alert_kind    (alert_kind),
	.event_count   (event_count),
	.latency_value (latency_value)
);

`default_nettype wire
